>>> sv/mdc_pkg.sv
// Package with the shared types of the determinant block.
`timescale 1ns / 1ps
package mdc_pkg;

  // Sequencer states of the determinant engine.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

>>> sv/matrix_determinant_cofactor.sv
// Determinant engine: loads a square matrix and expands it with one shared multiplier.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_stall, in_entry_value) carries one matrix
// element per request, row-major. The order n comes from cfg_matrix_size
// (values below two act as two, values above MAX_ORDER act as MAX_ORDER);
// writing it discards a partly loaded matrix.
// After the last element the block computes the determinant as a sum over
// all n! permutations, each signed by its parity. Every permutation term is
// a chain of n products through a single 64-bit multiplier, each product a
// read (fetch state) then a multiply (multiply state), followed by an
// accumulate state; after the last permutation the done state registers
// the result. The input stalls for all of the computation. The result
// appears on out_valid/out_determinant and is held while out_stall is
// high; the next matrix may load and compute meanwhile, but its result
// waits, with the input stalled, until the output register empties.
// Synchronous active-low reset clears the count, the sequencer and sets the
// order to four. The element store itself is not reset.
module matrix_determinant_cofactor #(
  parameter int MAX_ORDER   = 4,
  parameter int ENTRY_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_matrix_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [ENTRY_WIDTH-1:0] in_entry_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            out_determinant
);

  localparam int Depth = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int IW    = $clog2(MAX_ORDER);

  // Element store.
  logic [ENTRY_WIDTH-1:0] mem [Depth];
  logic [ENTRY_WIDTH-1:0] rd_data_r;

  logic [2:0]    size_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [OW-1:0] n_use;
  logic [CW-1:0] total;
  mdc_pkg::state_t state_r, state_nxt;

  // Permutation held as n column indexes; parity tracked as flips.
  logic [IW-1:0] perm_r [MAX_ORDER];
  logic [IW-1:0] perm_nxt [MAX_ORDER];
  logic          odd_r, odd_nxt;
  logic          last_perm;
  logic [IW-1:0] row_r;
  logic [63:0]   prod_r, acc_r;
  logic [63:0]   out_r;
  logic          out_v_r;

  always_comb begin
    if (size_r < 3'd2) n_use = OW'(2);
    else if (32'(size_r) > MAX_ORDER) n_use = OW'(MAX_ORDER);
    else n_use = OW'(size_r);
    total = CW'(n_use) * CW'(n_use);
  end

  assign in_stall = (state_r != mdc_pkg::ST_LOAD);
  wire in_acc = in_valid && !in_stall;

  // Next lexicographic permutation over the first n slots (narrow, independent search).
  always_comb begin
    int i, j, k;
    logic [IW-1:0] t;
    logic [IW-1:0] tmp [MAX_ORDER];
    logic flip;
    t = '0;
    for (k = 0; k < MAX_ORDER; k++) tmp[k] = perm_r[k];
    i = -1;
    for (k = 0; k < MAX_ORDER - 1; k++)
      if (k + 1 < int'(n_use) && perm_r[k] < perm_r[k+1]) i = k;
    last_perm = (i < 0);
    flip = 1'b0;
    j = 0;
    if (i >= 0) begin
      for (k = 0; k < MAX_ORDER; k++)
        if (k > i && k < int'(n_use) && perm_r[k] > perm_r[i]) j = k;
      t = tmp[i]; tmp[i] = tmp[j]; tmp[j] = t;
      flip = 1'b1;
      // Reverse the tail after i; count swaps for parity.
      for (k = 0; k < MAX_ORDER; k++) begin
        if (k > i && (int'(n_use) - 1 - (k - i - 1)) > k) begin
          t = tmp[k];
          tmp[k] = tmp[int'(n_use) - 1 - (k - i - 1)];
          tmp[int'(n_use) - 1 - (k - i - 1)] = t;
          flip = ~flip;
        end
      end
    end
    for (k = 0; k < MAX_ORDER; k++) perm_nxt[k] = tmp[k];
    odd_nxt = odd_r ^ flip;
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdc_pkg::ST_LOAD:  if (in_acc && (count_r + CW'(1) >= total)) state_nxt = mdc_pkg::ST_FETCH;
      mdc_pkg::ST_FETCH: state_nxt = mdc_pkg::ST_MUL;
      mdc_pkg::ST_MUL:   if (32'(row_r) + 1 >= int'(n_use)) state_nxt = mdc_pkg::ST_ACC;
                         else state_nxt = mdc_pkg::ST_FETCH;
      mdc_pkg::ST_ACC:   if (last_perm) state_nxt = mdc_pkg::ST_DONE;
                         else state_nxt = mdc_pkg::ST_FETCH;
      mdc_pkg::ST_DONE:  if (!out_v_r || !out_stall) state_nxt = mdc_pkg::ST_LOAD;
      default:           state_nxt = mdc_pkg::ST_LOAD;
    endcase
  end

  // Next element count.
  always_comb begin
    count_nxt = count_r;
    if (in_acc) count_nxt = (count_r + CW'(1) >= total) ? '0 : count_r + CW'(1);
  end

  // Store write and registered read of element (row, perm[row]).
  always_ff @(posedge clk) begin
    if (in_acc) mem[count_r[AW-1:0]] <= in_entry_value;
    rd_data_r <= mem[AW'(CW'(row_r) * CW'(n_use) + CW'(perm_r[row_r]))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdc_pkg::ST_LOAD;
      count_r <= '0;
      size_r  <= 3'd4;
      out_v_r <= 1'b0;
      row_r   <= '0;
      odd_r   <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) perm_r[k] <= IW'(k);
    end else begin
      state_r <= state_nxt;
      count_r <= cfg_we ? '0 : count_nxt;
      if (cfg_we) size_r <= cfg_matrix_size;
      // The done state refills the output register itself.
      if (out_v_r && !out_stall && state_r != mdc_pkg::ST_DONE) out_v_r <= 1'b0;
      unique case (state_r)
        mdc_pkg::ST_LOAD: begin
          row_r  <= '0;
          odd_r  <= 1'b0;
          prod_r <= 64'd1;
          acc_r  <= '0;
          for (int k = 0; k < MAX_ORDER; k++) perm_r[k] <= IW'(k);
        end
        mdc_pkg::ST_FETCH: ;
        mdc_pkg::ST_MUL: begin
          prod_r <= prod_r * {{(64-ENTRY_WIDTH){rd_data_r[ENTRY_WIDTH-1]}}, rd_data_r};
          if (32'(row_r) + 1 < int'(n_use)) row_r <= row_r + IW'(1);
        end
        mdc_pkg::ST_ACC: begin
          acc_r  <= odd_r ? acc_r - prod_r : acc_r + prod_r;
          prod_r <= 64'd1;
          row_r  <= '0;
          for (int k = 0; k < MAX_ORDER; k++) perm_r[k] <= perm_nxt[k];
          odd_r  <= odd_nxt;
        end
        mdc_pkg::ST_DONE: begin
          if (!out_v_r || !out_stall) begin
            out_v_r <= 1'b1;
            out_r   <= acc_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_v_r;
  assign out_determinant = out_r;

endmodule

>>> sv/mdc_checker.sv
// Port-level checker for the determinant block, bound to the top level.
`timescale 1ns / 1ps
module mdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_determinant
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_determinant))
    else $error("result changed under stall");

  // A stalled request stays offered.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("request dropped under stall");

  // After reset the block takes requests.
  a_rst: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("not ready after reset");

  // A new result never appears right after reset.
  a_nores: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result out of reset");

endmodule

bind matrix_determinant_cofactor mdc_checker u_mdc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_determinant(out_determinant)
);

>>> verif/tb_matrix_determinant_cofactor.sv
// Testbench for the determinant engine: randomized matrices checked against a local predictor.
`timescale 1ns / 1ps
module tb_matrix_determinant_cofactor;

  localparam int MAX_N = 4;
  localparam int EW = 12;
  localparam int CYCLE_LIMIT = 400000;

  // Scoreboard: holds the loaded matrix and the queue of expected determinants.
  class det_scoreboard;
    logic signed [EW-1:0] entries[MAX_N*MAX_N];
    int count;
    logic [2:0] size_reg;
    logic signed [63:0] pending_dets[$];
    int errors;
    int checked;

    function new();
      count = 0;
      size_reg = 3'd4;
      errors = 0;
      checked = 0;
    endfunction

    function int order();
      if (size_reg < 2) return 2;
      if (size_reg > MAX_N) return MAX_N;
      return size_reg;
    endfunction

    function void set_size(logic [2:0] v);
      size_reg = v;
      count = 0;
    endfunction

    // Laplace expansion along the first row, wrapping modulo 2^64.
    function logic [63:0] expand(logic [63:0] m[16], int k);
      logic [63:0] minor[16];
      logic [63:0] acc;
      logic [63:0] term;
      int mc;
      if (k == 2) return m[0] * m[MAX_N+1] - m[MAX_N] * m[1];
      acc = 0;
      for (int col = 0; col < k; col++) begin
        foreach (minor[i]) minor[i] = 0;
        for (int r = 1; r < k; r++) begin
          mc = 0;
          for (int c = 0; c < k; c++) begin
            if (c != col) begin
              minor[(r-1)*MAX_N + mc] = m[r*MAX_N + c];
              mc++;
            end
          end
        end
        term = m[col] * expand(minor, k - 1);
        if (col & 1) acc = acc - term;
        else acc = acc + term;
      end
      return acc;
    endfunction

    function void note_entry(logic signed [EW-1:0] v);
      logic [63:0] work[16];
      int n;
      n = order();
      entries[count] = v;
      count++;
      if (count < n*n) return;
      count = 0;
      foreach (work[i]) work[i] = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          work[r*MAX_N + c] = {{(64-EW){entries[r*n+c][EW-1]}}, entries[r*n+c]};
      pending_dets.push_back(expand(work, n));
    endfunction

    function void check_det(logic signed [63:0] got);
      logic signed [63:0] want;
      checked++;
      if (pending_dets.size() == 0) begin
        $display("%0t: unexpected determinant %0d", $time, got);
        errors++;
        return;
      end
      want = pending_dets.pop_front();
      if (got !== want) begin
        $display("%0t: determinant mismatch expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_matrix_size = 3'd4;
  logic in_valid = 0;
  logic in_stall;
  logic signed [EW-1:0] in_entry_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [63:0] out_determinant;

  det_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  int cycles = 0;
  int sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  matrix_determinant_cofactor uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_matrix_size(cfg_matrix_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_determinant(out_determinant)
  );

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stall, long hold-off on request, check accepted results.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_det(out_determinant);
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one entry, with optional random idle cycles ahead of it.
  task automatic send_entry(logic signed [EW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_entry_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_entry(v);
    sent++;
  endtask

  // Wait for all results, let the engine settle, then write the size.
  task automatic write_size(logic [2:0] v);
    in_valid <= 0;
    while (sb.pending_dets.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1;
    cfg_matrix_size <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_size(v);
  endtask

  function automatic logic signed [EW-1:0] rand_entry();
    case ($urandom_range(5))
      0: return -2048;
      1: return 2047;
      2: return $signed(EW'($urandom_range(7))) - 3;
      default: return EW'($urandom);
    endcase
  endfunction

  task automatic send_matrix(int n);
    for (int i = 0; i < n*n; i++) send_entry(rand_entry());
  endtask

  int phase_sizes[6] = '{4, 2, 3, 0, 7, 1};
  int wait_cnt;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: a 4x4 identity matrix, then four extreme values that start a matrix left partly loaded.
    for (int i = 0; i < 16; i++) send_entry((i % 5 == 0) ? 12'sd1 : 12'sd0);
    for (int i = 0; i < 4; i++) send_entry((i == 0 || i == 3) ? -12'sd2048 : 12'sd2047);

    // Size change while partly loaded drops the partial matrix.
    write_size(3'd3);
    send_entry(12'sd5);
    send_entry(12'sd7);
    write_size(3'd2);
    send_matrix(2);

    // Random phases cycling through all sizes and idle patterns.
    for (int p = 0; p < 6; p++) begin
      write_size(3'(phase_sizes[p]));
      if (p < 2) begin
        send_idle_pct = 20; recv_idle_pct = 88;
      end else if (p < 4) begin
        send_idle_pct = 88; recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (p == 4) begin
        // Hold the result side off long enough that the input backs up.
        fork
          begin
            hold_off = 1;
            wait_cnt = 0;
            while (wait_cnt < 600) begin
              @(posedge clk);
              wait_cnt++;
            end
            hold_off = 0;
          end
        join_none
      end
      while (sent < 40 + (p + 1) * 100) send_matrix(sb.order());
    end

    in_valid <= 0;
    while (sb.pending_dets.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d entries over sizes 2 to 4 and out-of-range size codes,", sent);
    $display("checked %0d determinants under varied stalls and back-pressure.", sb.checked);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
